### src/msl_pkg.sv
package msl_pkg;

   localparam int COUNT_W = 6;
   localparam int CSR_INDEX_W = 2;

   localparam int STEP_RESET = 175;
   localparam int COUNT_RESET = 2;
   localparam int COUNT_ZERO_SUBST = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_RISE_STEP,
      REG_FALL_STEP,
      REG_CHANNEL_COUNT
   } csr_reg_type;

endpackage

### src/msl_slew.sv
module msl_slew #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic signed [SAMPLE_BITS-1:0] prev,
   input  logic        [SAMPLE_BITS-2:0] rise_step,
   input  logic        [SAMPLE_BITS-2:0] fall_step,
   output logic signed [SAMPLE_BITS-1:0] result
);

   localparam int D_W = SAMPLE_BITS + 1;

   logic signed [D_W-1:0] diff;
   logic signed [D_W-1:0] lim;
   logic signed [D_W-1:0] lim_neg;
   logic signed [D_W-1:0] step;
   logic signed [D_W-1:0] sum;

   always_comb begin
      diff = D_W'(sample) - D_W'(prev);
      if (diff > 0) begin
         lim = $signed({2'b00, rise_step});
      end else begin
         lim = $signed({2'b00, fall_step});
      end
      lim_neg = -lim;
      if (diff > lim) begin
         step = lim;
      end else if (diff < lim_neg) begin
         step = lim_neg;
      end else begin
         step = diff;
      end
      sum = D_W'(prev) + step;
      // result lies between prev and sample, so the top bit is redundant
      result = sum[SAMPLE_BITS-1:0];
   end

endmodule

### src/multichannel_slew_limiter_unit.sv
// channel  ports                               item
// -------  ----------------------------------  ---------------------------------
// req      req_valid / req_stall               req_in_sample
// rsp      rsp_valid / rsp_stall               rsp_out_sample, rsp_out_channel
// csr      csr_we, csr_index, csr_wdata        write only
//
// Two register stages: input/history-read register, then result register.
// One item per cycle sustained while rsp_stall is low.
// The per-channel history read-modify-write is closed by a bypass of the
// result being written, so back-to-back items on one channel are exact.
// Reset clears history valid bits, channel counter and both stage valids.
// req_stall rises only when both stages hold an item and rsp_stall is high.
module multichannel_slew_limiter_unit #(
   parameter int MAX_CHANNELS = 32,
   parameter int SAMPLE_BITS  = 24
) (
   input  logic                                     clock,
   input  logic                                     reset,

   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [SAMPLE_BITS-1:0]            req_in_sample,

   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]            rsp_out_sample,
   output logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] rsp_out_channel,

   input  logic                                     csr_we,
   input  logic [msl_pkg::CSR_INDEX_W-1:0]          csr_index,
   input  logic [SAMPLE_BITS-2:0]                   csr_wdata
);

   localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int STEP_W = SAMPLE_BITS - 1;
   localparam int MAXC_W = $clog2(MAX_CHANNELS + 1);
   localparam int CMP_W = (MAXC_W > msl_pkg::COUNT_W) ? MAXC_W : msl_pkg::COUNT_W;

   // configuration
   logic [STEP_W-1:0]            rise_ff;
   logic [STEP_W-1:0]            fall_ff;
   logic [msl_pkg::COUNT_W-1:0]  count_ff;

   // channel counter
   logic [CH_W-1:0]              cnt_ff;
   logic [CH_W-1:0]              cnt_in;
   logic [CMP_W-1:0]             n_raw;
   logic [CMP_W-1:0]             n_eff;
   logic [CMP_W-1:0]             cnt_ext;
   logic [CMP_W-1:0]             ch_ext;
   logic [CMP_W-1:0]             ch_inc;
   logic [CH_W-1:0]              ch_cur;

   // history
   logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_CHANNELS];
   logic [MAX_CHANNELS-1:0]      hist_vld_ff;

   // stage 1
   logic                         s1_vld_ff;
   logic                         s1_vld_in;
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff;
   logic [CH_W-1:0]              s1_ch_ff;
   logic signed [SAMPLE_BITS-1:0] rd_mem_ff;
   logic                         rd_vld_ff;
   logic                         byp_ff;
   logic signed [SAMPLE_BITS-1:0] byp_data_ff;
   logic signed [SAMPLE_BITS-1:0] prev;
   logic signed [SAMPLE_BITS-1:0] y;

   // result stage
   logic                         out_vld_ff;
   logic                         out_vld_in;
   logic signed [SAMPLE_BITS-1:0] out_sample_ff;
   logic [CH_W-1:0]              out_ch_ff;

   logic                         accept;
   logic                         s1_adv;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         rise_ff  <= STEP_W'(msl_pkg::STEP_RESET);
         fall_ff  <= STEP_W'(msl_pkg::STEP_RESET);
         count_ff <= msl_pkg::COUNT_W'(msl_pkg::COUNT_RESET);
      end else if (csr_we) begin
         case (msl_pkg::csr_reg_type'(csr_index))
            msl_pkg::REG_RISE_STEP: begin
               rise_ff <= csr_wdata;
            end
            msl_pkg::REG_FALL_STEP: begin
               fall_ff <= csr_wdata;
            end
            msl_pkg::REG_CHANNEL_COUNT: begin
               count_ff <= csr_wdata[msl_pkg::COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // effective channel count and current channel
   always_comb begin
      if (count_ff == '0) begin
         n_raw = CMP_W'(msl_pkg::COUNT_ZERO_SUBST);
      end else begin
         n_raw = CMP_W'(count_ff);
      end
      if (n_raw > CMP_W'(MAX_CHANNELS)) begin
         n_eff = CMP_W'(MAX_CHANNELS);
      end else begin
         n_eff = n_raw;
      end
      cnt_ext = CMP_W'(cnt_ff);
      if (cnt_ext < n_eff) begin
         ch_ext = cnt_ext;
      end else begin
         ch_ext = '0;
      end
      ch_cur = ch_ext[CH_W-1:0];
      ch_inc = ch_ext + CMP_W'(1);
      if (ch_inc >= n_eff) begin
         cnt_in = '0;
      end else begin
         cnt_in = ch_inc[CH_W-1:0];
      end
   end

   // handshake
   assign s1_adv = s1_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = s1_vld_ff && !s1_adv;
   assign accept = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         s1_vld_in = 1'b1;
      end else if (s1_adv) begin
         s1_vld_in = 1'b0;
      end else begin
         s1_vld_in = s1_vld_ff;
      end
      if (s1_adv) begin
         out_vld_in = 1'b1;
      end else if (rsp_stall) begin
         out_vld_in = out_vld_ff;
      end else begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff   <= 1'b0;
         out_vld_ff  <= 1'b0;
         cnt_ff      <= '0;
         hist_vld_ff <= '0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
         if (accept) begin
            cnt_ff <= cnt_in;
         end
         if (s1_adv) begin
            hist_vld_ff[s1_ch_ff] <= 1'b1;
         end
      end
   end

   // history memory: write on stage-1 advance, read on accept
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         hist_mem[s1_ch_ff] <= y;
      end
      if (accept) begin
         rd_mem_ff <= hist_mem[ch_cur];
      end
   end

   // stage-1 payload; bypass covers a write to the channel being read
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff <= req_in_sample;
         s1_ch_ff     <= ch_cur;
         rd_vld_ff    <= hist_vld_ff[ch_cur];
         byp_ff       <= s1_adv && (s1_ch_ff == ch_cur);
         byp_data_ff  <= y;
      end
   end

   always_comb begin
      if (byp_ff) begin
         prev = byp_data_ff;
      end else if (rd_vld_ff) begin
         prev = rd_mem_ff;
      end else begin
         prev = '0;
      end
   end

   msl_slew #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_slew (
      .sample    (s1_sample_ff),
      .prev      (prev),
      .rise_step (rise_ff),
      .fall_step (fall_ff),
      .result    (y)
   );

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_sample_ff <= y;
         out_ch_ff     <= s1_ch_ff;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_out_sample  = out_sample_ff;
   assign rsp_out_channel = out_ch_ff;

   // assertions
   property p_stall_only_when_full;
      @(posedge clock) disable iff (reset)
         req_stall |-> (s1_vld_ff && out_vld_ff && rsp_stall);
   endproperty
   a_stall_only_when_full: assert property (p_stall_only_when_full)
      else $error("req_stall without both stages full");

   property p_adv_fills_output;
      @(posedge clock) disable iff (reset)
         s1_adv |=> out_vld_ff;
   endproperty
   a_adv_fills_output: assert property (p_adv_fills_output)
      else $error("stage-1 item lost on its way to the output");

   property p_hist_marked;
      @(posedge clock) disable iff (reset)
         s1_adv |=> hist_vld_ff[$past(s1_ch_ff)];
   endproperty
   a_hist_marked: assert property (p_hist_marked)
      else $error("history entry not marked after write");

   property p_channel_in_range;
      @(posedge clock) disable iff (reset)
         s1_vld_ff |-> (CMP_W'(s1_ch_ff) < n_eff);
   endproperty
   a_channel_in_range: assert property (p_channel_in_range)
      else $error("channel index beyond effective channel count");

endmodule
